[sv/banked_register_file_exception_entry_assert.svh]
// Assertion macros shared by the banked register file design.
`ifndef BANKED_REGISTER_FILE_EXCEPTION_ENTRY_ASSERT_SVH
`define BANKED_REGISTER_FILE_EXCEPTION_ENTRY_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define BRFEE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define BRFEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/brfee_pkg.sv]
// Shared types, codes and helper functions of the banked register file.
package brfee_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned VIEW_W    = 3;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned COND_W    = 4;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned EXC_W     = 2;
  localparam int unsigned MODE_W    = 5;
  localparam int unsigned SLOT_W    = 5;
  localparam int unsigned NUM_SLOTS = 27;

  // Operation kinds.
  localparam logic [KIND_W-1:0] KIND_READ_REG   = 4'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE_REG  = 4'd1;
  localparam logic [KIND_W-1:0] KIND_TEST_COND  = 4'd2;
  localparam logic [KIND_W-1:0] KIND_INT_STEP   = 4'd3;
  localparam logic [KIND_W-1:0] KIND_WRITE_CPSR = 4'd4;
  localparam logic [KIND_W-1:0] KIND_READ_SPSR  = 4'd5;
  localparam logic [KIND_W-1:0] KIND_WRITE_SPSR = 4'd6;
  localparam logic [KIND_W-1:0] KIND_RESTORE    = 4'd7;
  localparam logic [KIND_W-1:0] KIND_ADDR_CHECK = 4'd8;

  // Register views.
  localparam logic [VIEW_W-1:0] VIEW_CURRENT = 3'd0;
  localparam logic [VIEW_W-1:0] VIEW_USER    = 3'd1;
  localparam logic [VIEW_W-1:0] VIEW_FIQ     = 3'd2;
  localparam logic [VIEW_W-1:0] VIEW_IRQ     = 3'd3;
  localparam logic [VIEW_W-1:0] VIEW_SVC     = 3'd4;
  localparam logic [VIEW_W-1:0] VIEW_SYSTEM  = 3'd5;

  // Processor modes.
  localparam logic [MODE_W-1:0] MODE_USR  = 5'h10;
  localparam logic [MODE_W-1:0] MODE_FIQ  = 5'h11;
  localparam logic [MODE_W-1:0] MODE_IRQ  = 5'h12;
  localparam logic [MODE_W-1:0] MODE_SVC  = 5'h13;
  localparam logic [MODE_W-1:0] MODE_SYS  = 5'h1F;
  localparam logic [MODE_W-1:0] MODE_NONE = 5'h00;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_COND   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_SPSR    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_UNSUP_MODE = 2'd3;

  // Exception entry codes.
  localparam logic [EXC_W-1:0] EXC_NONE = 2'd0;
  localparam logic [EXC_W-1:0] EXC_IRQ  = 2'd1;
  localparam logic [EXC_W-1:0] EXC_FIQ  = 2'd2;
  localparam logic [EXC_W-1:0] EXC_SVC  = 2'd3;

  // Condition codes.
  localparam logic [COND_W-1:0] COND_EQ = 4'd0;
  localparam logic [COND_W-1:0] COND_NE = 4'd1;
  localparam logic [COND_W-1:0] COND_CS = 4'd2;
  localparam logic [COND_W-1:0] COND_CC = 4'd3;
  localparam logic [COND_W-1:0] COND_MI = 4'd4;
  localparam logic [COND_W-1:0] COND_PL = 4'd5;
  localparam logic [COND_W-1:0] COND_VS = 4'd6;
  localparam logic [COND_W-1:0] COND_VC = 4'd7;
  localparam logic [COND_W-1:0] COND_HI = 4'd8;
  localparam logic [COND_W-1:0] COND_LS = 4'd9;
  localparam logic [COND_W-1:0] COND_GE = 4'd10;
  localparam logic [COND_W-1:0] COND_LT = 4'd11;
  localparam logic [COND_W-1:0] COND_GT = 4'd12;
  localparam logic [COND_W-1:0] COND_LE = 4'd13;
  localparam logic [COND_W-1:0] COND_AL = 4'd14;
  localparam logic [COND_W-1:0] COND_NV = 4'd15;

  // Register slots of the banked store.
  localparam logic [SLOT_W-1:0] SLOT_PC   = 5'd15;
  localparam logic [SLOT_W-1:0] FIQ_BASE  = 5'd16;
  localparam logic [SLOT_W-1:0] IRQ_BASE  = 5'd23;
  localparam logic [SLOT_W-1:0] SVC_BASE  = 5'd25;
  localparam logic [IDX_W-1:0]  IDX_FIQ_LO = 4'd8;
  localparam logic [IDX_W-1:0]  IDX_SP    = 4'd13;
  localparam logic [IDX_W-1:0]  IDX_LR    = 4'd14;
  localparam logic [IDX_W-1:0]  IDX_PC    = 4'd15;

  // Status word layout and fixed values.
  localparam int unsigned      BIT_I        = 7;
  localparam int unsigned      BIT_F        = 6;
  localparam logic [XLEN-1:0]  CPSR_RESET   = 32'h0000_00D3;
  localparam logic [XLEN-1:0]  MODE_KEEP    = 32'hFFFF_FFE0;
  localparam logic [XLEN-1:0]  MASK_I_F     = 32'h0000_00C0;
  localparam logic [XLEN-1:0]  MASK_I       = 32'h0000_0080;
  localparam logic [XLEN-1:0]  VEC_IRQ      = 32'h0000_0018;
  localparam logic [XLEN-1:0]  VEC_FIQ      = 32'h0000_001C;
  localparam logic [XLEN-1:0]  VEC_SVC      = 32'h0000_0008;
  localparam logic [XLEN-1:0]  ADDR_LOW     = 32'h0000_8000;
  localparam logic [XLEN-1:0]  ADDR_HIGH    = 32'h8000_0000;
  localparam logic [XLEN-1:0]  PC_READ_OFS  = 32'd8;
  localparam logic [XLEN-1:0]  LR_OFS       = 32'd4;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] idx;
  } slot_t;

  // General register file write beat.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic [XLEN-1:0]   data;
  } rf_wr_t;

  // Program counter load on exception entry.
  typedef struct packed {
    logic            en;
    logic [XLEN-1:0] data;
  } pc_wr_t;

  // Maps an architectural register seen from a mode onto a storage slot.
  function automatic slot_t slot_of(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
    slot_t s;
    s.ok  = 1'b1;
    s.idx = SLOT_W'(idx);
    case (mode)
      MODE_USR, MODE_SYS: begin
      end
      MODE_FIQ: begin
        if (idx >= IDX_FIQ_LO && idx <= IDX_LR) begin
          s.idx = FIQ_BASE + SLOT_W'(idx) - SLOT_W'(IDX_FIQ_LO);
        end
      end
      MODE_IRQ: begin
        if (idx == IDX_SP || idx == IDX_LR) begin
          s.idx = IRQ_BASE + SLOT_W'(idx) - SLOT_W'(IDX_SP);
        end
      end
      MODE_SVC: begin
        if (idx == IDX_SP || idx == IDX_LR) begin
          s.idx = SVC_BASE + SLOT_W'(idx) - SLOT_W'(IDX_SP);
        end
      end
      default: begin
        s.ok  = 1'b0;
        s.idx = '0;
      end
    endcase
    return s;
  endfunction

  // Status word after an exception entry into the given mode.
  function automatic logic [XLEN-1:0] enter_status(logic [XLEN-1:0] cpsr,
                                                   logic [MODE_W-1:0] mode,
                                                   logic [XLEN-1:0] masks);
    return (cpsr & MODE_KEEP) | XLEN'(mode) | masks;
  endfunction

endpackage

[sv/brfee_cond.sv]
// Condition code evaluation against the NZCV flags.
module brfee_cond (
  input  logic [3:0]                   flags_i,
  input  logic [brfee_pkg::COND_W-1:0] cond_i,
  output logic                         pass_o
);
  import brfee_pkg::*;

  logic n, z, c, v;

  assign n = flags_i[3];
  assign z = flags_i[2];
  assign c = flags_i[1];
  assign v = flags_i[0];

  always_comb begin
    case (cond_i)
      COND_EQ: pass_o = z;
      COND_NE: pass_o = !z;
      COND_CS: pass_o = c;
      COND_CC: pass_o = !c;
      COND_MI: pass_o = n;
      COND_PL: pass_o = !n;
      COND_VS: pass_o = v;
      COND_VC: pass_o = !v;
      COND_HI: pass_o = c && !z;
      COND_LS: pass_o = !c || z;
      COND_GE: pass_o = (n == v);
      COND_LT: pass_o = (n != v);
      COND_GT: pass_o = !z && (n == v);
      COND_LE: pass_o = z || (n != v);
      COND_AL: pass_o = 1'b1;
      default: pass_o = 1'b0;
    endcase
  end

endmodule

[sv/brfee_regfile.sv]
// Banked register storage with one read port, one write port and a pc load.
module brfee_regfile (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [brfee_pkg::SLOT_W-1:0] rd_slot_i,
  output logic [brfee_pkg::XLEN-1:0]   rd_data_o,
  output logic [brfee_pkg::XLEN-1:0]   pc_o,
  input  brfee_pkg::rf_wr_t            wr_i,
  input  brfee_pkg::pc_wr_t            pc_wr_i
);
  import brfee_pkg::*;

  logic [XLEN-1:0] regs_q [NUM_SLOTS];

  // The pc load only comes with an exception entry, whose other write is
  // a link register, so the two ports never hit the same slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        regs_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (wr_i.en && wr_i.slot == SLOT_W'(i)) begin
          regs_q[i] <= wr_i.data;
        end else if (pc_wr_i.en && SLOT_PC == SLOT_W'(i)) begin
          regs_q[i] <= pc_wr_i.data;
        end
      end
    end
  end

  assign rd_data_o = regs_q[rd_slot_i];
  assign pc_o      = regs_q[SLOT_PC];

endmodule

[sv/banked_register_file_exception_entry.sv]
// Top level: mode-banked register file with status words and exception entry.
//
// One operation beat is accepted on every clock cycle in which start is
// high; busy is never raised, so a new beat may follow in the very next
// cycle. Each beat gives exactly one result beat, shown on the result ports
// for one cycle with done_o high, after it has passed through the input
// register and then through the execute logic into the result
// register. The receiver cannot stall, so results must be taken as they come.
// Because a beat updates the register file and status words at the end of
// its execute cycle, the beat that follows directly already sees that state.
// No clearing pass follows reset; the block is ready on the first cycle.
`include "banked_register_file_exception_entry_assert.svh"

module banked_register_file_exception_entry (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [brfee_pkg::KIND_W-1:0]   kind_i,
  input  logic [brfee_pkg::VIEW_W-1:0]   view_i,
  input  logic [brfee_pkg::IDX_W-1:0]    reg_index_i,
  input  logic [brfee_pkg::XLEN-1:0]     write_value_i,
  input  logic [brfee_pkg::COND_W-1:0]   cond_code_i,
  input  logic                           irq_line_i,
  input  logic                           fiq_line_i,
  input  logic [brfee_pkg::XLEN-1:0]     address_i,
  output logic                           done_o,
  output logic [brfee_pkg::XLEN-1:0]     read_data_o,
  output logic                           cond_pass_o,
  output logic [brfee_pkg::STATUS_W-1:0] status_code_o,
  output logic [brfee_pkg::EXC_W-1:0]    exception_taken_o,
  output logic [brfee_pkg::XLEN-1:0]     pc_value_o,
  output logic [brfee_pkg::XLEN-1:0]     status_word_o
);
  import brfee_pkg::*;

  // Input register.
  logic                vld_q;
  logic [KIND_W-1:0]   kind_q;
  logic [VIEW_W-1:0]   view_q;
  logic [IDX_W-1:0]    idx_q;
  logic [XLEN-1:0]     val_q;
  logic [COND_W-1:0]   cond_q;
  logic                irq_q;
  logic                fiq_q;
  logic [XLEN-1:0]     addr_q;

  // Architectural state outside the register file.
  logic [XLEN-1:0]     cpsr_q, cpsr_d;
  logic [XLEN-1:0]     saved_irq_q, saved_irq_d;
  logic [XLEN-1:0]     saved_fiq_q, saved_fiq_d;
  logic [XLEN-1:0]     saved_svc_q, saved_svc_d;
  logic                irq_pend_q, irq_pend_d;
  logic                fiq_pend_q, fiq_pend_d;

  // Result register.
  logic                done_q;
  logic [XLEN-1:0]     rd_q, rd_d;
  logic                pass_q, pass_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [EXC_W-1:0]    exc_q, exc_d;
  logic [XLEN-1:0]     pc_q, pc_d;

  // Execute-stage signals.
  logic [MODE_W-1:0]   mode_cur;
  logic [MODE_W-1:0]   mode_view;
  slot_t               slot;
  logic [XLEN-1:0]     rf_rd_data;
  logic [XLEN-1:0]     rf_pc;
  rf_wr_t              rf_wr;
  pc_wr_t              pc_wr;
  logic                cond_ok;
  logic                irq_p;
  logic                fiq_p;

  assign busy = 1'b0;

  // Input register: captures every accepted beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      kind_q <= kind_i;
      view_q <= view_i;
      idx_q  <= reg_index_i;
      val_q  <= write_value_i;
      cond_q <= cond_code_i;
      irq_q  <= irq_line_i;
      fiq_q  <= fiq_line_i;
      addr_q <= address_i;
    end
  end

  // Register view decode.
  assign mode_cur = cpsr_q[MODE_W-1:0];

  always_comb begin
    case (view_q)
      VIEW_CURRENT: mode_view = mode_cur;
      VIEW_USER:    mode_view = MODE_USR;
      VIEW_FIQ:     mode_view = MODE_FIQ;
      VIEW_IRQ:     mode_view = MODE_IRQ;
      VIEW_SVC:     mode_view = MODE_SVC;
      VIEW_SYSTEM:  mode_view = MODE_SYS;
      default:      mode_view = MODE_NONE;
    endcase
  end

  assign slot = slot_of(mode_view, idx_q);

  brfee_regfile u_regfile (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_slot_i (slot.idx),
    .rd_data_o (rf_rd_data),
    .pc_o      (rf_pc),
    .wr_i      (rf_wr),
    .pc_wr_i   (pc_wr)
  );

  brfee_cond u_cond (
    .flags_i (cpsr_q[XLEN-1:XLEN-4]),
    .cond_i  (cond_q),
    .pass_o  (cond_ok)
  );

  // Execute logic. Its register file writes are qualified by vld_q, and the
  // state registers load only on vld_q, so an idle cycle leaves the state alone.
  always_comb begin
    rd_d        = '0;
    pass_d      = 1'b0;
    status_d    = ST_OK;
    exc_d       = EXC_NONE;
    cpsr_d      = cpsr_q;
    saved_irq_d = saved_irq_q;
    saved_fiq_d = saved_fiq_q;
    saved_svc_d = saved_svc_q;
    irq_pend_d  = irq_pend_q;
    fiq_pend_d  = fiq_pend_q;
    rf_wr       = '0;
    pc_wr       = '0;
    irq_p       = irq_pend_q || irq_q;
    fiq_p       = fiq_pend_q || fiq_q;

    case (kind_q)
      KIND_READ_REG: begin
        // A current-view pc read sees the pipeline offset, even when the
        // current mode is not a supported one.
        if (view_q == VIEW_CURRENT && idx_q == IDX_PC) begin
          rd_d = rf_pc + PC_READ_OFS;
        end else if (!slot.ok) begin
          status_d = ST_UNSUP_MODE;
        end else begin
          rd_d = rf_rd_data;
        end
      end
      KIND_WRITE_REG: begin
        if (!slot.ok) begin
          status_d = ST_UNSUP_MODE;
        end else begin
          rf_wr.en   = vld_q;
          rf_wr.slot = slot.idx;
          rf_wr.data = val_q;
        end
      end
      KIND_TEST_COND: begin
        if (cond_q == COND_NV) begin
          status_d = ST_BAD_COND;
        end else begin
          pass_d = cond_ok;
        end
      end
      KIND_INT_STEP: begin
        // IRQ wins over FIQ; its entry masks F, so only one entry per beat.
        if (irq_p && !cpsr_q[BIT_I]) begin
          irq_p       = 1'b0;
          saved_irq_d = cpsr_q;
          cpsr_d      = enter_status(cpsr_q, MODE_IRQ, MASK_I_F);
          rf_wr.en    = vld_q;
          rf_wr.slot  = IRQ_BASE + SLOT_W'(IDX_LR - IDX_SP);
          rf_wr.data  = rf_pc + LR_OFS;
          pc_wr.en    = vld_q;
          pc_wr.data  = VEC_IRQ;
          exc_d       = EXC_IRQ;
        end else if (fiq_p && !cpsr_q[BIT_F]) begin
          fiq_p       = 1'b0;
          saved_fiq_d = cpsr_q;
          cpsr_d      = enter_status(cpsr_q, MODE_FIQ, MASK_I_F);
          rf_wr.en    = vld_q;
          rf_wr.slot  = FIQ_BASE + SLOT_W'(IDX_LR - IDX_FIQ_LO);
          rf_wr.data  = rf_pc + LR_OFS;
          pc_wr.en    = vld_q;
          pc_wr.data  = VEC_FIQ;
          exc_d       = EXC_FIQ;
        end
        irq_pend_d = irq_p;
        fiq_pend_d = fiq_p;
      end
      KIND_WRITE_CPSR: begin
        cpsr_d = val_q;
      end
      KIND_READ_SPSR, KIND_WRITE_SPSR, KIND_RESTORE: begin
        case (mode_cur)
          MODE_SVC: begin
            if (kind_q == KIND_READ_SPSR) begin
              rd_d = saved_svc_q;
            end else if (kind_q == KIND_WRITE_SPSR) begin
              saved_svc_d = val_q;
            end else begin
              cpsr_d = saved_svc_q;
            end
          end
          MODE_IRQ: begin
            if (kind_q == KIND_READ_SPSR) begin
              rd_d = saved_irq_q;
            end else if (kind_q == KIND_WRITE_SPSR) begin
              saved_irq_d = val_q;
            end else begin
              cpsr_d = saved_irq_q;
            end
          end
          MODE_FIQ: begin
            if (kind_q == KIND_READ_SPSR) begin
              rd_d = saved_fiq_q;
            end else if (kind_q == KIND_WRITE_SPSR) begin
              saved_fiq_d = val_q;
            end else begin
              cpsr_d = saved_fiq_q;
            end
          end
          MODE_USR, MODE_SYS: status_d = ST_NO_SPSR;
          default:            status_d = ST_UNSUP_MODE;
        endcase
      end
      KIND_ADDR_CHECK: begin
        // A user-mode access outside the allowed window faults into
        // supervisor mode with the I mask set and the F mask left as it was.
        if (mode_cur == MODE_USR && (addr_q < ADDR_LOW || addr_q > ADDR_HIGH)) begin
          saved_svc_d = cpsr_q;
          cpsr_d      = enter_status(cpsr_q, MODE_SVC, MASK_I);
          rf_wr.en    = vld_q;
          rf_wr.slot  = SVC_BASE + SLOT_W'(IDX_LR - IDX_SP);
          rf_wr.data  = rf_pc + LR_OFS;
          pc_wr.en    = vld_q;
          pc_wr.data  = VEC_SVC;
          exc_d       = EXC_SVC;
        end
      end
      default: begin
      end
    endcase

    // Program counter as it stands once this beat has retired.
    pc_d = rf_pc;
    if (rf_wr.en && rf_wr.slot == SLOT_PC) begin
      pc_d = rf_wr.data;
    end
    if (pc_wr.en) begin
      pc_d = pc_wr.data;
    end
  end

  // Status word, saved status words and pending interrupt bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpsr_q      <= CPSR_RESET;
      saved_irq_q <= '0;
      saved_fiq_q <= '0;
      saved_svc_q <= '0;
      irq_pend_q  <= 1'b0;
      fiq_pend_q  <= 1'b0;
    end else if (vld_q) begin
      cpsr_q      <= cpsr_d;
      saved_irq_q <= saved_irq_d;
      saved_fiq_q <= saved_fiq_d;
      saved_svc_q <= saved_svc_d;
      irq_pend_q  <= irq_pend_d;
      fiq_pend_q  <= fiq_pend_d;
    end
  end

  // Result register: one beat out for every beat executed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_q) begin
      rd_q     <= rd_d;
      pass_q   <= pass_d;
      status_q <= status_d;
      exc_q    <= exc_d;
      pc_q     <= pc_d;
    end
  end

  assign done_o            = done_q;
  assign read_data_o       = rd_q;
  assign cond_pass_o       = pass_q;
  assign status_code_o     = status_q;
  assign exception_taken_o = exc_q;
  assign pc_value_o        = pc_q;
  assign status_word_o     = cpsr_q;

  // Every executed beat yields exactly one result beat in the next cycle.
  `BRFEE_ASSERT_NEXT(a_result_follows, vld_q, done_q, "executed beat gave no result")
  `BRFEE_ASSERT_NEXT(a_no_spurious_result, !vld_q, !done_q, "result without a beat")
  // An IRQ entry lands in IRQ mode on its vector with both masks set.
  `BRFEE_ASSERT_IMP(a_irq_entry, done_q && exc_q == EXC_IRQ,
    pc_q == VEC_IRQ && cpsr_q[MODE_W-1:0] == MODE_IRQ && cpsr_q[BIT_I] && cpsr_q[BIT_F]
      && !irq_pend_q, "IRQ entry left wrong state")
  // A fault entry lands in supervisor mode on its vector.
  `BRFEE_ASSERT_IMP(a_svc_entry, done_q && exc_q == EXC_SVC,
    pc_q == VEC_SVC && cpsr_q[MODE_W-1:0] == MODE_SVC && cpsr_q[BIT_I],
    "fault entry left wrong state")
  // An operation that reports an error takes no exception and keeps the pc.
  `BRFEE_ASSERT_IMP(a_error_no_effect, done_q && status_q != ST_OK,
    exc_q == EXC_NONE && pc_q == rf_pc, "failed operation changed the pc")

endmodule

[sim/banked_register_file_exception_entry_tb.sv]
// Self-checking testbench for the mode-banked register file with exception entry.
module banked_register_file_exception_entry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brfee_pkg::*;

  // Codes that the package leaves unnamed but that the stimulus must reach:
  // the no-operation kinds above the address check, and the two view codes
  // that map onto no mode at all.
  localparam logic [KIND_W-1:0] KIND_NOP_LO = 4'd9;
  localparam logic [KIND_W-1:0] KIND_NOP_HI = 4'd15;
  localparam logic [VIEW_W-1:0] VIEW_BAD_LO = 3'd6;
  localparam logic [VIEW_W-1:0] VIEW_BAD_HI = 3'd7;

  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PHASE_BEATS  = 284;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One operation beat as the sender presents it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [VIEW_W-1:0] view;
    logic [IDX_W-1:0]  idx;
    logic [XLEN-1:0]   wval;
    logic [COND_W-1:0] cond;
    logic              irq;
    logic              fiq;
    logic [XLEN-1:0]   addr;
  } op_t;

  // One result beat as the block shows it.
  typedef struct packed {
    logic [XLEN-1:0]     read_data;
    logic                cond_pass;
    logic [STATUS_W-1:0] status;
    logic [EXC_W-1:0]    taken;
    logic [XLEN-1:0]     pc;
    logic [XLEN-1:0]     cpsr;
  } outcome_t;

  // The tracker keeps its own copy of the banked registers, the status words
  // and the pending interrupt bits. Every accepted operation is played on that
  // copy at once, and the outcome it should give is queued until the block
  // shows its result beat.
  class regbank_tracker;
    logic [XLEN-1:0] regs [NUM_SLOTS];
    logic [XLEN-1:0] cpsr;
    logic [XLEN-1:0] saved_irq;
    logic [XLEN-1:0] saved_fiq;
    logic [XLEN-1:0] saved_svc;
    logic            irq_pend;
    logic            fiq_pend;
    outcome_t        outcome_q[$];
    int unsigned     mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      cpsr       = CPSR_RESET;
      saved_irq  = '0;
      saved_fiq  = '0;
      saved_svc  = '0;
      irq_pend   = 1'b0;
      fiq_pend   = 1'b0;
      mismatches = 0;
    endfunction

    // Storage slot of a register seen from a mode, or -1 for a mode that
    // does not exist.
    function int bank_slot(logic [MODE_W-1:0] mode, logic [IDX_W-1:0] idx);
      int r;
      r = int'(idx);
      case (mode)
        MODE_USR, MODE_SYS: begin
        end
        MODE_FIQ: begin
          if (idx >= IDX_FIQ_LO && idx <= IDX_LR) r = int'(FIQ_BASE) + r - int'(IDX_FIQ_LO);
        end
        MODE_IRQ: begin
          if (idx == IDX_SP || idx == IDX_LR) r = int'(IRQ_BASE) + r - int'(IDX_SP);
        end
        MODE_SVC: begin
          if (idx == IDX_SP || idx == IDX_LR) r = int'(SVC_BASE) + r - int'(IDX_SP);
        end
        default: begin
          r = -1;
        end
      endcase
      return r;
    endfunction

    function logic [MODE_W-1:0] view_mode(logic [VIEW_W-1:0] view);
      case (view)
        VIEW_CURRENT: return cpsr[MODE_W-1:0];
        VIEW_USER:    return MODE_USR;
        VIEW_FIQ:     return MODE_FIQ;
        VIEW_IRQ:     return MODE_IRQ;
        VIEW_SVC:     return MODE_SVC;
        VIEW_SYSTEM:  return MODE_SYS;
        default:      return MODE_NONE;
      endcase
    endfunction

    function logic cond_holds(logic [COND_W-1:0] cond);
      logic n, z, c, v;
      n = cpsr[31];
      z = cpsr[30];
      c = cpsr[29];
      v = cpsr[28];
      case (cond)
        COND_EQ: return z;
        COND_NE: return !z;
        COND_CS: return c;
        COND_CC: return !c;
        COND_MI: return n;
        COND_PL: return !n;
        COND_VS: return v;
        COND_VC: return !v;
        COND_HI: return c && !z;
        COND_LS: return !c || z;
        COND_GE: return n == v;
        COND_LT: return n != v;
        COND_GT: return !z && (n == v);
        COND_LE: return z || (n != v);
        COND_AL: return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    // Saved status word of a mode that has one; callers check the mode.
    function logic [XLEN-1:0] saved_of(logic [MODE_W-1:0] mode);
      case (mode)
        MODE_IRQ: return saved_irq;
        MODE_FIQ: return saved_fiq;
        default:  return saved_svc;
      endcase
    endfunction

    // Exception entry: save the status word, switch mode, raise the masks,
    // leave the return address in the target's lr and jump to the vector.
    function void enter_mode(logic [MODE_W-1:0] mode, logic [XLEN-1:0] masks,
                             logic [XLEN-1:0] vector);
      case (mode)
        MODE_IRQ: saved_irq = cpsr;
        MODE_FIQ: saved_fiq = cpsr;
        default:  saved_svc = cpsr;
      endcase
      cpsr = (cpsr & MODE_KEEP) | XLEN'(mode) | masks;
      regs[bank_slot(mode, IDX_LR)] = regs[SLOT_PC] + LR_OFS;
      regs[SLOT_PC] = vector;
    endfunction

    function void note_op(op_t op);
      outcome_t         o;
      int               s;
      logic [MODE_W-1:0] m;
      o = '0;
      case (op.kind)
        KIND_READ_REG: begin
          // The pc read through the current view runs ahead by eight, in any
          // mode, even one that does not exist.
          if (op.view == VIEW_CURRENT && op.idx == IDX_PC) begin
            o.read_data = regs[SLOT_PC] + PC_READ_OFS;
          end else begin
            s = bank_slot(view_mode(op.view), op.idx);
            if (s < 0) o.status = ST_UNSUP_MODE;
            else o.read_data = regs[s];
          end
        end
        KIND_WRITE_REG: begin
          s = bank_slot(view_mode(op.view), op.idx);
          if (s < 0) o.status = ST_UNSUP_MODE;
          else regs[s] = op.wval;
        end
        KIND_TEST_COND: begin
          if (op.cond == COND_NV) o.status = ST_BAD_COND;
          else o.cond_pass = cond_holds(op.cond);
        end
        KIND_INT_STEP: begin
          irq_pend = irq_pend | op.irq;
          fiq_pend = fiq_pend | op.fiq;
          // IRQ entry masks F as well, so the FIQ test below sees it masked.
          if (irq_pend && !cpsr[BIT_I]) begin
            irq_pend = 1'b0;
            enter_mode(MODE_IRQ, MASK_I_F, VEC_IRQ);
            o.taken = EXC_IRQ;
          end
          if (fiq_pend && !cpsr[BIT_F]) begin
            fiq_pend = 1'b0;
            enter_mode(MODE_FIQ, MASK_I_F, VEC_FIQ);
            o.taken = EXC_FIQ;
          end
        end
        KIND_WRITE_CPSR: begin
          cpsr = op.wval;
        end
        KIND_READ_SPSR, KIND_WRITE_SPSR, KIND_RESTORE: begin
          m = cpsr[MODE_W-1:0];
          if (m == MODE_IRQ || m == MODE_FIQ || m == MODE_SVC) begin
            case (op.kind)
              KIND_READ_SPSR: begin
                o.read_data = saved_of(m);
              end
              KIND_WRITE_SPSR: begin
                case (m)
                  MODE_IRQ: saved_irq = op.wval;
                  MODE_FIQ: saved_fiq = op.wval;
                  default:  saved_svc = op.wval;
                endcase
              end
              default: begin
                cpsr = saved_of(m);
              end
            endcase
          end else if (m == MODE_USR || m == MODE_SYS) begin
            o.status = ST_NO_SPSR;
          end else begin
            o.status = ST_UNSUP_MODE;
          end
        end
        KIND_ADDR_CHECK: begin
          if (cpsr[MODE_W-1:0] == MODE_USR && (op.addr < ADDR_LOW || op.addr > ADDR_HIGH)) begin
            enter_mode(MODE_SVC, MASK_I, VEC_SVC);
            o.taken = EXC_SVC;
          end
        end
        default: begin
        end
      endcase
      o.pc   = regs[SLOT_PC];
      o.cpsr = cpsr;
      outcome_q.push_back(o);
    endfunction

    function void check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      end
    endfunction

    function void check_outcome(outcome_t got);
      outcome_t want;
      if (outcome_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with none expected, expected nothing, got pc %h cpsr %h",
                 $time, got.pc, got.cpsr);
        return;
      end
      want = outcome_q.pop_front();
      check_field("read_data", want.read_data, got.read_data);
      check_field("cond_pass", XLEN'(want.cond_pass), XLEN'(got.cond_pass));
      check_field("status_code", XLEN'(want.status), XLEN'(got.status));
      check_field("exception_taken", XLEN'(want.taken), XLEN'(got.taken));
      check_field("pc_value", want.pc, got.pc);
      check_field("status_word", want.cpsr, got.cpsr);
    endfunction
  endclass

  // Clock, reset and every block input start at known values.
  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                start         = 1'b0;
  logic [KIND_W-1:0]   kind_i        = '0;
  logic [VIEW_W-1:0]   view_i        = '0;
  logic [IDX_W-1:0]    reg_index_i   = '0;
  logic [XLEN-1:0]     write_value_i = '0;
  logic [COND_W-1:0]   cond_code_i   = '0;
  logic                irq_line_i    = 1'b0;
  logic                fiq_line_i    = 1'b0;
  logic [XLEN-1:0]     address_i     = '0;
  logic                busy;
  logic                done_o;
  logic [XLEN-1:0]     read_data_o;
  logic                cond_pass_o;
  logic [STATUS_W-1:0] status_code_o;
  logic [EXC_W-1:0]    exception_taken_o;
  logic [XLEN-1:0]     pc_value_o;
  logic [XLEN-1:0]     status_word_o;

  regbank_tracker sb = new();
  int unsigned    cycle_count = 0;

  banked_register_file_exception_entry dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .kind_i            (kind_i),
    .view_i            (view_i),
    .reg_index_i       (reg_index_i),
    .write_value_i     (write_value_i),
    .cond_code_i       (cond_code_i),
    .irq_line_i        (irq_line_i),
    .fiq_line_i        (fiq_line_i),
    .address_i         (address_i),
    .done_o            (done_o),
    .read_data_o       (read_data_o),
    .cond_pass_o       (cond_pass_o),
    .status_code_o     (status_code_o),
    .exception_taken_o (exception_taken_o),
    .pc_value_o        (pc_value_o),
    .status_word_o     (status_word_o)
  );

  always #5 clk_i = ~clk_i;

  // Monitor. Inputs move only on the falling edge, so at the rising edge
  // everything is settled, and the block's own updates from this edge have
  // not landed yet. The accepted beat is noted before the result is checked,
  // so the order of the two never matters whatever the latency.
  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      sb.note_op('{kind: kind_i, view: view_i, idx: reg_index_i, wval: write_value_i,
                   cond: cond_code_i, irq: irq_line_i, fiq: fiq_line_i, addr: address_i});
    end
    if (rst_ni && done_o) begin
      sb.check_outcome('{read_data: read_data_o, cond_pass: cond_pass_o,
                         status: status_code_o, taken: exception_taken_o,
                         pc: pc_value_o, cpsr: status_word_o});
    end
  end

  // Watchdog: a lost or stuck result beat ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic op_t mk(logic [KIND_W-1:0] kind, logic [VIEW_W-1:0] view,
                             logic [IDX_W-1:0] idx, logic [XLEN-1:0] wval,
                             logic [COND_W-1:0] cond, logic irq, logic fiq,
                             logic [XLEN-1:0] addr);
    op_t op;
    op.kind = kind;
    op.view = view;
    op.idx  = idx;
    op.wval = wval;
    op.cond = cond;
    op.irq  = irq;
    op.fiq  = fiq;
    op.addr = addr;
    return op;
  endfunction

  // Status word values for cpsr and spsr writes. Most carry a real mode and
  // often clear masks, so that interrupts and faults actually get taken; the
  // rest are raw values, unsupported modes included.
  function automatic logic [XLEN-1:0] status_pattern();
    logic [XLEN-1:0] v;
    int unsigned     pick;
    pick = $urandom_range(99);
    v = $urandom;
    if (pick < 80) begin
      case ($urandom_range(6))
        0, 1, 2: v[MODE_W-1:0] = MODE_USR;
        3:       v[MODE_W-1:0] = MODE_FIQ;
        4:       v[MODE_W-1:0] = MODE_IRQ;
        5:       v[MODE_W-1:0] = MODE_SVC;
        default: v[MODE_W-1:0] = MODE_SYS;
      endcase
      if ($urandom_range(1)) v[BIT_I] = 1'b0;
      if ($urandom_range(1)) v[BIT_F] = 1'b0;
    end else if (pick >= 90) begin
      v = $urandom_range(1) ? '1 : '0;
    end
    return v;
  endfunction

  // Addresses cluster at both edges of the user window and at the extremes.
  function automatic logic [XLEN-1:0] pick_address();
    case ($urandom_range(4))
      0:       return $urandom;
      1:       return ADDR_LOW + XLEN'($urandom_range(3)) - XLEN'(2);
      2:       return ADDR_HIGH + XLEN'($urandom_range(3)) - XLEN'(2);
      3:       return $urandom_range(1) ? '1 : '0;
      default: return XLEN'($urandom_range(32'h7FFF));
    endcase
  endfunction

  function automatic op_t random_op();
    op_t         op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) op.view = VIEW_CURRENT;
    else if (pick < 95) op.view = VIEW_W'($urandom_range(VIEW_USER, VIEW_SYSTEM));
    else op.view = VIEW_W'($urandom_range(VIEW_BAD_LO, VIEW_BAD_HI));
    op.idx = IDX_W'($urandom);
    case ($urandom_range(9))
      0:       op.wval = '0;
      1:       op.wval = '1;
      default: op.wval = $urandom;
    endcase
    op.cond = COND_W'($urandom);
    op.irq  = 1'($urandom);
    op.fiq  = 1'($urandom);
    op.addr = pick_address();
    pick = $urandom_range(99);
    if (pick < 18) begin
      op.kind = KIND_READ_REG;
    end else if (pick < 36) begin
      op.kind = KIND_WRITE_REG;
    end else if (pick < 46) begin
      op.kind = KIND_TEST_COND;
    end else if (pick < 58) begin
      op.kind = KIND_INT_STEP;
    end else if (pick < 70) begin
      op.kind = KIND_WRITE_CPSR;
      op.wval = status_pattern();
    end else if (pick < 75) begin
      op.kind = KIND_READ_SPSR;
    end else if (pick < 81) begin
      op.kind = KIND_WRITE_SPSR;
      op.wval = status_pattern();
    end else if (pick < 86) begin
      op.kind = KIND_RESTORE;
    end else if (pick < 97) begin
      op.kind = KIND_ADDR_CHECK;
    end else begin
      op.kind = KIND_W'($urandom_range(KIND_NOP_LO, KIND_NOP_HI));
    end
    return op;
  endfunction

  task automatic apply_fields(op_t op);
    kind_i        <= op.kind;
    view_i        <= op.view;
    reg_index_i   <= op.idx;
    write_value_i <= op.wval;
    cond_code_i   <= op.cond;
    irq_line_i    <= op.irq;
    fiq_line_i    <= op.fiq;
    address_i     <= op.addr;
  endtask

  // Sends one beat. Entered and left on a falling edge. Idle cycles come
  // first, with noise on the fields while start is low; start stays high
  // across back-to-back beats, since it is assigned once per falling edge.
  task automatic drive_op(op_t op, int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      apply_fields(random_op());
      @(negedge clk_i);
    end
    start <= 1'b1;
    apply_fields(op);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    op_t         directed_q[$];
    int unsigned idle_by_phase[6];
    idle_by_phase = '{0, 63, 6, 0, 63, 6};

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats. Reset leaves the block in supervisor mode with both
    // interrupts masked and every register zero.
    directed_q.push_back(mk(KIND_READ_REG, VIEW_CURRENT, IDX_PC, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_WRITE_REG, VIEW_CURRENT, 4'd0, '1, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_WRITE_REG, VIEW_USER, IDX_PC, 32'h1000, COND_EQ, 0, 0, '0));
    // Current-view pc read runs eight ahead; a named view does not.
    directed_q.push_back(mk(KIND_READ_REG, VIEW_CURRENT, IDX_PC, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_READ_REG, VIEW_SVC, IDX_PC, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_WRITE_REG, VIEW_FIQ, IDX_FIQ_LO, 32'hA5A5_A5A5, COND_EQ,
                            0, 0, '0));
    // Views that name no mode.
    directed_q.push_back(mk(KIND_READ_REG, VIEW_BAD_LO, 4'd0, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_WRITE_REG, VIEW_BAD_HI, IDX_SP, '1, COND_EQ, 0, 0, '1));
    directed_q.push_back(mk(KIND_TEST_COND, VIEW_CURRENT, 4'd0, '0, COND_NV, 0, 0, '0));
    directed_q.push_back(mk(KIND_READ_SPSR, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    // User mode with Z and C set: no saved status word, EQ holds.
    directed_q.push_back(mk(KIND_WRITE_CPSR, VIEW_CURRENT, 4'd0, 32'h6000_0010, COND_EQ,
                            0, 0, '0));
    directed_q.push_back(mk(KIND_READ_SPSR, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_TEST_COND, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    // Fault below the window, then read back and restore the saved word.
    directed_q.push_back(mk(KIND_ADDR_CHECK, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0,
                            32'h0000_7FFF));
    directed_q.push_back(mk(KIND_READ_SPSR, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_RESTORE, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    // The top of the window is still legal; one above it faults.
    directed_q.push_back(mk(KIND_ADDR_CHECK, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0,
                            ADDR_HIGH));
    directed_q.push_back(mk(KIND_ADDR_CHECK, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0,
                            32'h8000_0001));
    // Both lines at once: IRQ wins, FIQ stays pending until F is clear.
    directed_q.push_back(mk(KIND_WRITE_CPSR, VIEW_CURRENT, 4'd0, 32'h0000_0010, COND_EQ,
                            0, 0, '0));
    directed_q.push_back(mk(KIND_INT_STEP, VIEW_CURRENT, 4'd0, '0, COND_EQ, 1, 1, '0));
    directed_q.push_back(mk(KIND_WRITE_CPSR, VIEW_CURRENT, 4'd0, 32'h0000_0092, COND_EQ,
                            0, 0, '0));
    directed_q.push_back(mk(KIND_INT_STEP, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    // A mode that does not exist: current-view access fails, but the pc read
    // through the current view still works.
    directed_q.push_back(mk(KIND_WRITE_CPSR, VIEW_CURRENT, 4'd0, 32'hF000_000A, COND_EQ,
                            0, 0, '0));
    directed_q.push_back(mk(KIND_READ_REG, VIEW_CURRENT, 4'd0, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_READ_REG, VIEW_CURRENT, IDX_PC, '0, COND_EQ, 0, 0, '0));
    directed_q.push_back(mk(KIND_NOP_HI, VIEW_BAD_HI, IDX_PC, '1, COND_NV, 1, 1, '1));
    foreach (directed_q[i]) drive_op(directed_q[i], 0);

    // Random beats in phases of different sender idling.
    foreach (idle_by_phase[p]) begin
      repeat (PHASE_BEATS) drive_op(random_op(), idle_by_phase[p]);
    end
    start <= 1'b0;

    // Let every outstanding result beat come back, then keep the clock running so
    // that a stray extra beat would still be seen.
    while (sb.outcome_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
